[hw/rtl/lkv_pkg.sv]
// Shared types and constants for the LRU key/value cache.
// Used by lkv_front, lkv_back and lru_key_value_cache; no dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int LKV_ENTRIES    = 16;
    localparam int LKV_DATA_W     = 32;
    localparam int LKV_CAP_W      = 5;
    localparam int LKV_CAP_RESET  = 16;
    localparam int LKV_QDEPTH     = 2;
    localparam int LKV_QPW        = 1;
    localparam int LKV_QCW        = 2;
    localparam int LKV_APB_DW     = 32;
    localparam int LKV_ADDR_W     = 3;
    localparam int LKV_REG_IDX_W  = 1;

    localparam logic [LKV_REG_IDX_W-1:0] LKV_REG_CAPACITY = 1'b0;
    localparam logic signed [LKV_DATA_W-1:0] LKV_MISS_VALUE = -32'sd1;

    typedef enum logic
    {
        LKV_OP_GET,
        LKV_OP_PUT
    } lkv_op_e_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_MATCH,
        BK_COMMIT
    } lkv_bk_state_t;

    typedef struct packed
    {
        logic                         func;
        logic signed [LKV_DATA_W-1:0] key;
        logic signed [LKV_DATA_W-1:0] value;
    } lkv_in_t;

    typedef struct packed
    {
        logic                         hit;
        logic signed [LKV_DATA_W-1:0] read_value;
    } lkv_out_t;

    typedef struct packed
    {
        lkv_op_e_t                    op;
        logic signed [LKV_DATA_W-1:0] key;
        logic signed [LKV_DATA_W-1:0] value;
    } lkv_cmd_t;

    // queue head as seen by the back end
    typedef struct packed
    {
        logic     valid;
        lkv_cmd_t cmd;
    } lkv_q_t;

endpackage

[hw/rtl/lkv_front.sv]
// Front end: accepts input transactions, decodes the operation and queues commands.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  lkv_pkg::lkv_in_t in_item,
    output lkv_pkg::lkv_q_t  q,
    input  logic             pop
);

    lkv_pkg::lkv_cmd_t                 mem [lkv_pkg::LKV_QDEPTH];
    logic [lkv_pkg::LKV_QPW-1:0]       wr_ptr_reg;
    logic [lkv_pkg::LKV_QPW-1:0]       wr_ptr_next;
    logic [lkv_pkg::LKV_QPW-1:0]       rd_ptr_reg;
    logic [lkv_pkg::LKV_QPW-1:0]       rd_ptr_next;
    logic [lkv_pkg::LKV_QCW-1:0]       count_reg;
    logic [lkv_pkg::LKV_QCW-1:0]       count_next;
    logic                              push;
    logic                              do_pop;
    lkv_pkg::lkv_cmd_t                 cmd_in;

    always_comb
    begin
        cmd_in.op    = in_item.func ? lkv_pkg::LKV_OP_PUT : lkv_pkg::LKV_OP_GET;
        cmd_in.key   = in_item.key;
        cmd_in.value = in_item.value;
    end

    assign in_ready = (count_reg != lkv_pkg::LKV_QCW'(lkv_pkg::LKV_QDEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + lkv_pkg::LKV_QPW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + lkv_pkg::LKV_QPW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + lkv_pkg::LKV_QCW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - lkv_pkg::LKV_QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_comb
    begin
        q.valid = (count_reg != '0);
        q.cmd   = mem[rd_ptr_reg];
    end

endmodule

[hw/rtl/lkv_back.sv]
// Back end: entry store, parallel key match, age-rank update and output register.
// Depends on lkv_pkg; fed by lkv_front.
`timescale 1ns / 1ps

module lkv_back
#(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [lkv_pkg::LKV_CAP_W-1:0]           cap,
    input  lkv_pkg::lkv_q_t                         q,
    output logic                                    pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output lkv_pkg::lkv_out_t                       out_item,
    output logic [$clog2(ENTRIES+1)-1:0]            occupancy,
    output logic [ENTRIES-1:0]                      entry_valid
);

    localparam int OW = $clog2(ENTRIES + 1);
    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LW = (OW > lkv_pkg::LKV_CAP_W) ? OW + 1 : lkv_pkg::LKV_CAP_W + 1;

    lkv_pkg::lkv_bk_state_t               state_reg;
    lkv_pkg::lkv_bk_state_t               state_next;
    lkv_pkg::lkv_cmd_t                    item_reg;

    logic [lkv_pkg::LKV_DATA_W-1:0]       keys_reg [ENTRIES];
    logic signed [lkv_pkg::LKV_DATA_W-1:0] vals_reg [ENTRIES];
    logic [ENTRIES-1:0]                   valid_reg;
    logic [ENTRIES-1:0]                   valid_next;
    logic [RW-1:0]                        rank_reg [ENTRIES];
    logic [RW-1:0]                        rank_next [ENTRIES];
    logic [OW-1:0]                        occ_reg;
    logic [OW-1:0]                        occ_next;

    logic                                 hit_reg;
    logic [RW-1:0]                        hit_idx_reg;
    logic [RW-1:0]                        old_idx_reg;
    logic [RW-1:0]                        free_idx_reg;

    logic                                 out_valid_reg;
    lkv_pkg::lkv_out_t                    out_item_reg;
    lkv_pkg::lkv_out_t                    out_item_next;

    logic [ENTRIES-1:0]                   match_vec;
    logic [RW-1:0]                        hit_idx;
    logic [RW-1:0]                        old_idx;
    logic [RW-1:0]                        free_idx;
    logic [OW-1:0]                        occ_m1;
    logic [LW-1:0]                        limit;
    logic                                 full;
    logic                                 out_free;
    logic                                 commit;
    logic                                 is_put;
    logic [RW-1:0]                        slot;
    logic [RW-1:0]                        hit_rank;

    // ---------------- lookup stage ----------------
    assign occ_m1 = occ_reg - OW'(1);

    always_comb
    begin
        hit_idx  = '0;
        old_idx  = '0;
        free_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_reg[i] && (keys_reg[i] == item_reg.key);
            if (match_vec[i])
            begin
                hit_idx = hit_idx | RW'(i);
            end
            // valid ranks are distinct 0..occ-1, so the oldest is unique
            if (valid_reg[i] && (rank_reg[i] == occ_m1[RW-1:0]))
            begin
                old_idx = old_idx | RW'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = RW'(i);
            end
        end
    end

    // ---------------- commit stage ----------------
    always_comb
    begin
        if (cap == '0)
        begin
            limit = LW'(1);
        end
        else if (LW'(cap) > LW'(ENTRIES))
        begin
            limit = LW'(ENTRIES);
        end
        else
        begin
            limit = LW'(cap);
        end
    end

    assign full     = (LW'(occ_reg) >= limit);
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == lkv_pkg::BK_COMMIT) && out_free;
    assign is_put   = (item_reg.op == lkv_pkg::LKV_OP_PUT);
    assign slot     = hit_reg ? hit_idx_reg : (full ? old_idx_reg : free_idx_reg);
    assign hit_rank = rank_reg[hit_idx_reg];

    always_comb
    begin
        valid_next = valid_reg;
        occ_next   = occ_reg;
        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        if (commit)
        begin
            if (hit_reg)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (RW'(i) != hit_idx_reg) && (rank_reg[i] < hit_rank))
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                rank_next[hit_idx_reg] = '0;
            end
            else if (is_put)
            begin
                // insert or evict: every other valid entry ages by one
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (RW'(i) != slot))
                    begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
                rank_next[slot]  = '0;
                valid_next[slot] = 1'b1;
                if (!full)
                begin
                    occ_next = occ_reg + OW'(1);
                end
            end
        end
    end

    always_comb
    begin
        out_item_next.hit = hit_reg;
        if (is_put)
        begin
            out_item_next.read_value = '0;
        end
        else if (hit_reg)
        begin
            out_item_next.read_value = vals_reg[hit_idx_reg];
        end
        else
        begin
            out_item_next.read_value = lkv_pkg::LKV_MISS_VALUE;
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            lkv_pkg::BK_IDLE:
            begin
                if (q.valid)
                begin
                    pop        = 1'b1;
                    state_next = lkv_pkg::BK_MATCH;
                end
            end
            lkv_pkg::BK_MATCH:
            begin
                state_next = lkv_pkg::BK_COMMIT;
            end
            lkv_pkg::BK_COMMIT:
            begin
                if (out_free)
                begin
                    pop        = q.valid;
                    state_next = q.valid ? lkv_pkg::BK_MATCH : lkv_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = lkv_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lkv_pkg::BK_IDLE;
            valid_reg     <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            occ_reg   <= occ_next;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= q.cmd;
        end
        if (state_reg == lkv_pkg::BK_MATCH)
        begin
            hit_reg      <= |match_vec;
            hit_idx_reg  <= hit_idx;
            old_idx_reg  <= old_idx;
            free_idx_reg <= free_idx;
        end
        if (commit)
        begin
            out_item_reg <= out_item_next;
            if (is_put)
            begin
                vals_reg[slot] <= item_reg.value;
                if (!hit_reg)
                begin
                    keys_reg[slot] <= item_reg.key;
                end
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_item    = out_item_reg;
    assign occupancy   = occ_reg;
    assign entry_valid = valid_reg;

endmodule

[hw/rtl/lru_key_value_cache.sv]
// LRU key/value cache: top level with the capacity register and its APB port.
// Depends on lkv_pkg, lkv_front and lkv_back.
//
// Usage:
//   Input channel (in_valid/in_ready/in_item) carries get (func 0) or put (func 1)
//   transactions with a 32-bit key and value. Output channel (out_valid/out_ready/
//   out_item) returns one transaction per input: hit, and read_value (stored value
//   on get hit, -1 on get miss, 0 on put).
//   When the block is empty, an accepted input passes the command queue, then the
//   back end MATCH and COMMIT states, before out_valid rises. The back end finishes
//   one transaction (parallel key compare, store and age-rank update) before the next.
//   A 2-entry command queue sits between the front end and the back end, so
//   input transactions keep being accepted while a result waits in the output
//   register. When out_ready stays low the result holds, the back end stops
//   and the queue fills, after which in_ready drops.
//   Reset clears all valid marks, age ranks and occupancy and sets the capacity
//   register (address 0) to 16. No clearing pass is needed. Capacity must be written
//   over APB only while no transaction is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module lru_key_value_cache
#(
    parameter int ENTRIES = lkv_pkg::LKV_ENTRIES
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lkv_pkg::lkv_in_t                  in_item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lkv_pkg::lkv_out_t                 out_item,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkv_pkg::LKV_ADDR_W-1:0]    paddr,
    input  logic [lkv_pkg::LKV_APB_DW-1:0]    pwdata,
    output logic [lkv_pkg::LKV_APB_DW-1:0]    prdata,
    output logic                              pready
);

    localparam int OW = $clog2(ENTRIES + 1);

    logic [lkv_pkg::LKV_CAP_W-1:0]       cap_reg;
    logic [lkv_pkg::LKV_CAP_W-1:0]       cap_next;
    logic [lkv_pkg::LKV_REG_IDX_W-1:0]   reg_idx;
    logic                                cfg_wr;
    lkv_pkg::lkv_q_t                     q;
    logic                                pop;
    logic [OW-1:0]                       occupancy;
    logic [ENTRIES-1:0]                  entry_valid;

    assign pready  = 1'b1;
    assign reg_idx = paddr[lkv_pkg::LKV_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_wr && (reg_idx == lkv_pkg::LKV_REG_CAPACITY))
        begin
            cap_next = pwdata[lkv_pkg::LKV_CAP_W-1:0];
        end
    end

    always_comb
    begin
        if (reg_idx == lkv_pkg::LKV_REG_CAPACITY)
        begin
            prdata = lkv_pkg::LKV_APB_DW'(cap_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= lkv_pkg::LKV_CAP_W'(lkv_pkg::LKV_CAP_RESET);
        end
        else
        begin
            cap_reg <= cap_next;
        end
    end

    lkv_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .q        (q),
        .pop      (pop)
    );

    lkv_back
    #(
        .ENTRIES (ENTRIES)
    )
    u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cap         (cap_reg),
        .q           (q),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .occupancy   (occupancy),
        .entry_valid (entry_valid)
    );

`ifndef SYNTHESIS
    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(entry_valid) == int'(occupancy))
        else $error("occupancy does not match valid entry count");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(occupancy) <= ENTRIES)
        else $error("occupancy above entry count");

    a_cap_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (reg_idx == lkv_pkg::LKV_REG_CAPACITY))
        |=> (cap_reg == $past(pwdata[lkv_pkg::LKV_CAP_W-1:0])))
        else $error("capacity register not updated by write");
`endif

endmodule

[sim/lkv_bench_pkg.sv]
// Scoreboard for the LRU key/value cache bench: access predictor and the FIFO
// of predicted replies. Depends on lkv_pkg.
`timescale 1ns / 1ps

package lkv_bench_pkg;

    import lkv_pkg::*;

    class lkv_scoreboard;

        logic signed [LKV_DATA_W-1:0] slot_key [LKV_ENTRIES];
        logic signed [LKV_DATA_W-1:0] slot_value [LKV_ENTRIES];
        bit                           slot_live [LKV_ENTRIES];
        logic [3:0]                   slot_age [LKV_ENTRIES];
        logic [LKV_CAP_W-1:0]         fill;
        logic [LKV_CAP_W-1:0]         capacity;
        lkv_out_t                     predicted_replies [$];
        int unsigned                  error_count;

        function new();
            capacity = LKV_CAP_W'(LKV_CAP_RESET);
            fill = '0;
            error_count = 0;
            foreach (slot_live[i])
            begin
                slot_live[i] = 1'b0;
                slot_age[i] = '0;
            end
        endfunction

        function void set_capacity(input logic [LKV_CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int live_limit();
            if (capacity == 0)
                return 1;
            if (capacity > LKV_ENTRIES)
                return LKV_ENTRIES;
            return int'(capacity);
        endfunction

        // slot s becomes most recent; live slots younger than it age by one
        function void promote(input int s);
            logic [3:0] rank;
            rank = slot_age[s];
            for (int i = 0; i < LKV_ENTRIES; i++)
                if (slot_live[i] && i != s && slot_age[i] < rank)
                    slot_age[i] = slot_age[i] + 1'b1;
            slot_age[s] = '0;
        endfunction

        function int outstanding();
            return predicted_replies.size();
        endfunction

        function void note_error(input string msg);
            error_count++;
            if (error_count <= 10)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        // predict the reply of one accepted request transaction
        function void accept_request(input lkv_in_t req);
            int       s;
            int       victim;
            lkv_out_t rep;
            s = -1;
            for (int i = 0; i < LKV_ENTRIES; i++)
                if (s < 0 && slot_live[i] && slot_key[i] == req.key)
                    s = i;
            rep.hit = (s >= 0);
            if (lkv_op_e_t'(req.func) == LKV_OP_GET)
            begin
                if (s >= 0)
                begin
                    rep.read_value = slot_value[s];
                    promote(s);
                end
                else
                    rep.read_value = LKV_MISS_VALUE;
            end
            else
            begin
                rep.read_value = '0;
                if (s >= 0)
                begin
                    promote(s);
                    slot_value[s] = req.value;
                end
                else
                begin
                    if (int'(fill) >= live_limit())
                    begin
                        // replace the oldest live slot, occupancy unchanged
                        victim = -1;
                        for (int i = 0; i < LKV_ENTRIES; i++)
                            if (slot_live[i] &&
                                (victim < 0 || slot_age[i] > slot_age[victim]))
                                victim = i;
                        s = victim;
                        promote(s);
                    end
                    else
                    begin
                        for (int i = 0; i < LKV_ENTRIES; i++)
                            if (s < 0 && !slot_live[i])
                                s = i;
                        for (int i = 0; i < LKV_ENTRIES; i++)
                            if (slot_live[i])
                                slot_age[i] = slot_age[i] + 1'b1;
                        slot_live[s] = 1'b1;
                        slot_age[s] = '0;
                        fill = fill + 1'b1;
                    end
                    slot_key[s] = req.key;
                    slot_value[s] = req.value;
                end
            end
            predicted_replies.push_back(rep);
        endfunction

        function void check_reply(input lkv_out_t got);
            lkv_out_t want;
            if (predicted_replies.size() == 0)
            begin
                note_error($sformatf("unexpected reply: hit %0b read_value %0d",
                                     got.hit, got.read_value));
                return;
            end
            want = predicted_replies.pop_front();
            if (got.hit !== want.hit)
                note_error($sformatf("hit: expected %0b, got %0b", want.hit, got.hit));
            if (got.read_value !== want.read_value)
                note_error($sformatf("read_value: expected %0d, got %0d",
                                     want.read_value, got.read_value));
        endfunction

        function void close_out();
            if (predicted_replies.size() != 0)
                note_error($sformatf("%0d replies never arrived",
                                     predicted_replies.size()));
        endfunction

    endclass

endpackage

[sim/lru_key_value_cache_test.sv]
// Top-level bench for lru_key_value_cache: drives get/put transactions and
// capacity writes, checks replies. Depends on lkv_pkg and lkv_bench_pkg.
`timescale 1ns / 1ps

module lru_key_value_cache_test;

    import lkv_pkg::*;
    import lkv_bench_pkg::*;

    localparam logic signed [LKV_DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [LKV_DATA_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 160;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    lkv_in_t               in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [LKV_ADDR_W-1:0] paddr     = '0;
    logic [LKV_APB_DW-1:0] pwdata    = '0;
    logic                  in_ready;
    logic                  out_valid;
    lkv_out_t              out_item;
    logic [LKV_APB_DW-1:0] prdata;
    logic                  pready;

    bit send_gaps   = 1'b1;
    bit recv_stalls = 1'b1;

    lkv_scoreboard sb = new();
    logic signed [LKV_DATA_W-1:0] key_pool [$];
    logic [LKV_CAP_W-1:0] phase_caps [PHASES] =
        '{5'd3, 5'd5, 5'd1, 5'd8, 5'd12, 5'd16, 5'd17, 5'd31, 5'd2, 5'd0};

    lru_key_value_cache uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reply(out_item);
        out_ready <= !(recv_stalls && $urandom_range(99) < 8);
    end

    // in_valid stays high after an accepted transaction; the next call,
    // drain_replies or a mid-phase pause in run_phase decides whether it drops
    task automatic send_access(input lkv_op_e_t op,
                               input logic signed [LKV_DATA_W-1:0] k,
                               input logic signed [LKV_DATA_W-1:0] v);
        lkv_in_t item;
        item.func = op;
        item.key = k;
        item.value = v;
        while (send_gaps && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.accept_request(item);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        // pipeline settles past the last reply
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [LKV_CAP_W-1:0] cap);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LKV_ADDR_W'(4 * LKV_REG_CAPACITY);
        pwdata <= LKV_APB_DW'(cap);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_capacity(cap);
    endtask

    function automatic logic signed [LKV_DATA_W-1:0] edge_word();
        case ($urandom_range(3))
            0: return KEY_MIN;
            1: return KEY_MAX;
            2: return '0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic signed [LKV_DATA_W-1:0] pick_key();
        if ($urandom_range(99) < 10)
            return $urandom();
        return key_pool[$urandom_range(key_pool.size() - 1)];
    endfunction

    function automatic logic signed [LKV_DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 10)
            return edge_word();
        return $urandom();
    endfunction

    task automatic run_phase(input logic [LKV_CAP_W-1:0] cap, input int items,
                             input bit pause_mid);
        int lim;
        int n;
        write_capacity(cap);
        lim = (cap == 0) ? 1 : (cap > LKV_ENTRIES) ? LKV_ENTRIES : int'(cap);
        // pool a bit larger than the capacity keeps both hits and evictions common
        n = lim + $urandom_range(lim + 2, 1);
        key_pool.delete();
        repeat (n)
            key_pool.push_back(($urandom_range(99) < 10) ? edge_word()
                                                          : $signed($urandom()));
        for (int i = 0; i < items; i++)
        begin
            if (pause_mid && i == items / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (sb.outstanding() != 0)
                    @(posedge clk);
            end
            send_access(($urandom_range(99) < 50) ? LKV_OP_GET : LKV_OP_PUT,
                        pick_key(), pick_value());
        end
        drain_replies();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity: misses on empty store, extreme keys and values, overwrite
        send_access(LKV_OP_GET, 32'sd0, 32'sd0);
        send_access(LKV_OP_PUT, KEY_MIN, KEY_MAX);
        send_access(LKV_OP_PUT, KEY_MAX, KEY_MIN);
        send_access(LKV_OP_PUT, 32'sd0, 32'sd0);
        send_access(LKV_OP_PUT, -32'sd1, -32'sd1);
        send_access(LKV_OP_GET, KEY_MIN, 32'sd0);
        send_access(LKV_OP_GET, KEY_MAX, -32'sd1);
        send_access(LKV_OP_GET, -32'sd1, 32'sd0);
        send_access(LKV_OP_PUT, KEY_MIN, 32'sh1234_5678);
        send_access(LKV_OP_GET, KEY_MIN, 32'sd0);
        send_access(LKV_OP_GET, 32'sh5555_5555, 32'sd0);
        drain_replies();

        // capacity zero acts as one, and sits below the current occupancy
        write_capacity(5'd0);
        send_access(LKV_OP_PUT, 32'shAAAA_AAAA, 32'shDEAD_BEEF);
        send_access(LKV_OP_GET, 32'shAAAA_AAAA, 32'sd0);
        send_access(LKV_OP_GET, KEY_MIN, 32'sd0);
        send_access(LKV_OP_PUT, 32'sd1, 32'sd7);
        send_access(LKV_OP_GET, 32'shAAAA_AAAA, 32'sd0);
        send_access(LKV_OP_GET, 32'sd1, 32'sd0);
        drain_replies();

        phase_caps[PHASES-1] = LKV_CAP_W'($urandom_range(31));
        for (int p = 0; p < PHASES; p++)
        begin
            send_gaps = (p != 5);
            recv_stalls = (p != 5);
            run_phase(phase_caps[p], PHASE_ITEMS, p == 2 || p == 7);
        end

        sb.close_out();
        if (sb.error_count == 0)
            $display("PASS lru_key_value_cache");
        else
            $display("FAIL lru_key_value_cache");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("FAIL lru_key_value_cache");
        $finish;
    end

endmodule

[files.f]
hw/rtl/lkv_pkg.sv
hw/rtl/lkv_front.sv
hw/rtl/lkv_back.sv
hw/rtl/lru_key_value_cache.sv
sim/lkv_bench_pkg.sv
sim/lru_key_value_cache_test.sv
